[design/fsi_pkg.sv]
package fsi_pkg;

  localparam int NUM_CHAN_DEF = 8;
  localparam int MAX_REP = 3;

  typedef enum logic [2:0] {
    ST_BOOT     = 3'd0,
    ST_IDLE     = 3'd1,
    ST_ARMED    = 3'd2,
    ST_PREFIRE  = 3'd3,
    ST_FIRING   = 3'd4,
    ST_POSTFIRE = 3'd5,
    ST_LINKLOST = 3'd6,
    ST_ERROR    = 3'd7
  } st_t;

  localparam logic [3:0] CMD_TICK      = 4'd0;
  localparam logic [3:0] CMD_LINK_UP   = 4'd1;
  localparam logic [3:0] CMD_ARM       = 4'd2;
  localparam logic [3:0] CMD_DISARM    = 4'd3;
  localparam logic [3:0] CMD_CEASE     = 4'd4;
  localparam logic [3:0] CMD_LAUNCH    = 4'd5;
  localparam logic [3:0] CMD_SENSE     = 4'd6;
  localparam logic [3:0] CMD_KEY       = 4'd7;
  localparam logic [3:0] CMD_BATT_CRIT = 4'd8;
  localparam logic [3:0] CMD_LINK_LOST = 4'd9;
  localparam logic [3:0] CMD_LINK_REC  = 4'd10;
  localparam logic [3:0] CMD_WELD      = 4'd11;
  localparam logic [3:0] CMD_PULSE_END = 4'd12;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_NACK = 2'd2;

  localparam logic [1:0] MSG_ARM    = 2'd0;
  localparam logic [1:0] MSG_DISARM = 2'd1;
  localparam logic [1:0] MSG_CEASE  = 2'd2;
  localparam logic [1:0] MSG_FIRE   = 2'd3;

  localparam logic [7:0] NK_INVALID_CH    = 8'd0;
  localparam logic [7:0] NK_ALREADY_ARMED = 8'd1;
  localparam logic [7:0] NK_SWITCH_OFF    = 8'd2;
  localparam logic [7:0] NK_NO_CONT       = 8'd3;
  localparam logic [7:0] NK_LOW_BATT      = 8'd4;
  localparam logic [7:0] NK_COMM          = 8'd5;
  localparam logic [7:0] NK_WRONG_STATE   = 8'd6;
  localparam logic [7:0] NK_SENSE_FAULT   = 8'd7;

  localparam logic [1:0] ERRB_NONE  = 2'd0;
  localparam logic [1:0] ERRB_RELAY = 2'd1;
  localparam logic [1:0] ERRB_VBAT  = 2'd2;

  localparam logic [2:0] SIREN_QUIET = 3'd0;
  localparam logic [2:0] SIREN_PULSE = 3'd1;
  localparam logic [2:0] SIREN_CONT  = 3'd2;
  localparam logic [2:0] SIREN_LINK  = 3'd3;
  localparam logic [2:0] SIREN_ERR   = 3'd4;

  localparam logic [2:0] LED_STATUS  = 3'd0;
  localparam logic [2:0] LED_ARMED   = 3'd1;
  localparam logic [2:0] LED_PREFIRE = 3'd2;
  localparam logic [2:0] LED_FIRING  = 3'd3;
  localparam logic [2:0] LED_ERROR   = 3'd4;

  localparam logic [2:0] REG_ARM_TO    = 3'd0;
  localparam logic [2:0] REG_PREFIRE   = 3'd1;
  localparam logic [2:0] REG_AUTH_TO   = 3'd2;
  localparam logic [2:0] REG_COOLDOWN  = 3'd3;
  localparam logic [2:0] REG_VERIFY_TO = 3'd4;
  localparam logic [2:0] REG_MIN_BATT  = 3'd5;
  localparam logic [2:0] REG_PROT_MASK = 3'd6;
  localparam logic [2:0] REG_PULSE_LL  = 3'd7;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] time_ms;
    logic [7:0]  channel;
    logic [31:0] cmd_seq;
    logic [31:0] rx_time_ms;
    logic        level;
    logic        key_on;
    logic        arm_sense_on;
    logic        continuity_open;
    logic [15:0] battery_mv;
    logic        link_healthy;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  reply_kind;
    logic [1:0]  reply_msg;
    logic [31:0] reply_seq;
    logic [7:0]  reply_value;
    logic [2:0]  fsm_state;
    logic [3:0]  armed_chan;
    logic [1:0]  error_bits;
    logic        arm_relay;
    logic [3:0]  fire_relay_chan;
    logic [2:0]  siren_mode;
    logic [2:0]  led_mode;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] arm_to;
    logic [31:0] prefire;
    logic [31:0] auth_to;
    logic [31:0] cooldown;
    logic [15:0] verify_to;
    logic [15:0] min_batt;
    logic [7:0]  prot_mask;
    logic        pulse_ll;
  } cfg_t;

  typedef struct packed {
    st_t         st;
    logic [3:0]  ach;
    logic [3:0]  fch;
    logic [1:0]  ef;
    logic [31:0] ast;
    logic [31:0] pst;
    logic [31:0] post;
    logic        vp;
    logic [3:0]  vch;
    logic [31:0] vst;
    logic [31:0] vseq;
    logic        llp;
    logic [31:0] lft;
    logic        arr;
    logic [3:0]  frr;
    logic [2:0]  sir;
    logic [2:0]  led;
  } core_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  msg;
    logic [31:0] seq;
    logic [7:0]  val;
  } reply_t;

  typedef struct packed {
    logic [1:0]   n;
    reply_t [2:0] rep;
  } rep_list_t;

  typedef struct packed {
    st_t        st;
    logic [3:0] ach;
    logic [1:0] ef;
    logic       arr;
    logic [3:0] frr;
    logic [2:0] sir;
    logic [2:0] led;
  } status_t;

  typedef struct packed {
    rep_list_t r;
    status_t   s;
  } bundle_t;

  function automatic rep_list_t push(rep_list_t l, logic [1:0] k, logic [1:0] m,
                                     logic [31:0] sq, logic [7:0] v);
    rep_list_t o;
    o = l;
    if (o.n < 2'(MAX_REP)) begin
      o.rep[o.n] = '{kind: k, msg: m, seq: sq, val: v};
      o.n = o.n + 2'd1;
    end
    return o;
  endfunction

  function automatic core_t relays_safe(core_t s);
    core_t o;
    o = s;
    o.arr = 1'b0;
    o.frr = 4'd0;
    return o;
  endfunction

  function automatic core_t clear_common(core_t s);
    core_t o;
    o = relays_safe(s);
    o.ach = 4'd0;
    o.fch = 4'd0;
    o.ast = 32'd0;
    o.pst = 32'd0;
    o.lft = 32'd0;
    o.llp = 1'b0;
    o.led = LED_STATUS;
    return o;
  endfunction

  function automatic core_t go_disarm(core_t s);
    core_t o;
    o = clear_common(s);
    o.sir = SIREN_QUIET;
    o.st = ST_IDLE;
    return o;
  endfunction

  function automatic core_t go_link_lost(core_t s);
    core_t o;
    o = clear_common(s);
    o.sir = SIREN_LINK;
    o.st = ST_LINKLOST;
    return o;
  endfunction

  function automatic core_t go_error(core_t s, logic [1:0] flag);
    core_t o;
    o = clear_common(s);
    o.sir = SIREN_ERR;
    o.led = LED_ERROR;
    o.ef = o.ef | flag;
    o.post = 32'd0;
    o.st = ST_ERROR;
    return o;
  endfunction

  function automatic core_t verify_clear(core_t s);
    core_t o;
    o = s;
    o.vp = 1'b0;
    o.vch = 4'd0;
    o.vst = 32'd0;
    return o;
  endfunction

  function automatic core_t firing_to_idle(core_t s);
    core_t o;
    o = relays_safe(s);
    o.sir = SIREN_QUIET;
    o.fch = 4'd0;
    o.ach = 4'd0;
    o.llp = 1'b0;
    o.led = LED_STATUS;
    o.st = ST_IDLE;
    return o;
  endfunction

endpackage

[design/fsi_if.sv]
interface fsi_in_if;
  import fsi_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface fsi_out_if;
  import fsi_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

[design/fsi_step.sv]
module fsi_step #(
  parameter int NUM_CHAN = fsi_pkg::NUM_CHAN_DEF
) (
  input  fsi_pkg::core_t   cur_i,
  input  fsi_pkg::cfg_t    cfg_i,
  input  fsi_pkg::in_item_t item_i,
  output fsi_pkg::core_t   nxt_o,
  output fsi_pkg::bundle_t bundle_o
);
  import fsi_pkg::*;

  always_comb begin
    core_t       s;
    rep_list_t   l;
    logic [31:0] t;
    logic [7:0]  ch;
    logic [7:0]  g;
    logic        g_fail;
    logic [3:0]  vc;
    logic        dm;
    logic        nlvl;

    s = cur_i;
    l = '0;
    vc = 4'd0;
    dm = 1'b0;
    t = item_i.time_ms;
    ch = item_i.channel;
    nlvl = (item_i.cmd == CMD_SENSE || item_i.cmd == CMD_KEY) && !item_i.level;

    // arming guard, first failing check wins
    g_fail = 1'b1;
    g = NK_INVALID_CH;
    if (ch == 8'd0 || ch > 8'(NUM_CHAN)) g = NK_INVALID_CH;
    else if (s.ach != 4'd0) g = NK_ALREADY_ARMED;
    else if (!cfg_i.prot_mask[3'(ch - 8'd1)]) g = NK_INVALID_CH;
    else if (!item_i.key_on) g = NK_SWITCH_OFF;
    else if (item_i.continuity_open) g = NK_NO_CONT;
    else if (item_i.battery_mv < cfg_i.min_batt) g = NK_LOW_BATT;
    else if (!item_i.link_healthy) g = NK_COMM;
    else g_fail = 1'b0;

    // event rule
    if (item_i.cmd == CMD_WELD) begin
      if (s.st != ST_ERROR) begin
        if (s.vp) begin
          s = verify_clear(s);
          l = push(l, KIND_NACK, MSG_ARM, s.vseq, NK_SENSE_FAULT);
        end
        s = go_error(s, ERRB_RELAY);
      end
    end else begin
      unique case (s.st)
        ST_BOOT: begin
          if (item_i.cmd == CMD_LINK_UP) begin
            s.st = ST_IDLE;
            s.led = LED_STATUS;
          end
        end
        ST_IDLE: begin
          if (item_i.cmd == CMD_ARM) begin
            if (g_fail) l = push(l, KIND_NACK, MSG_ARM, item_i.cmd_seq, g);
            else begin
              s.arr = 1'b1;
              if (item_i.arm_sense_on) begin
                s.ach = ch[3:0];
                s.ast = t;
                s.sir = SIREN_PULSE;
                s.led = LED_ARMED;
                l = push(l, KIND_ACK, MSG_ARM, item_i.cmd_seq, ch);
                s.st = ST_ARMED;
              end else begin
                s.vp = 1'b1;
                s.vch = ch[3:0];
                s.vseq = item_i.cmd_seq;
                s.vst = t;
              end
            end
          end else if (item_i.cmd == CMD_SENSE) begin
            if (s.vp && item_i.level) begin
              vc = s.vch;
              s = verify_clear(s);
              s.ach = vc;
              s.ast = t;
              s.sir = SIREN_PULSE;
              s.led = LED_ARMED;
              l = push(l, KIND_ACK, MSG_ARM, s.vseq, {4'd0, vc});
              s.st = ST_ARMED;
            end
          end else if (item_i.cmd == CMD_DISARM) begin
            l = push(l, KIND_ACK, MSG_DISARM, item_i.cmd_seq, ch);
          end else if (item_i.cmd == CMD_CEASE) begin
            if (s.vp) begin
              s = verify_clear(relays_safe(s));
              l = push(l, KIND_NACK, MSG_ARM, s.vseq, NK_WRONG_STATE);
            end
            l = push(l, KIND_ACK, MSG_CEASE, item_i.cmd_seq, 8'd0);
          end else if (item_i.cmd == CMD_LAUNCH) begin
            if (s.vp) begin
              s = verify_clear(relays_safe(s));
              l = push(l, KIND_NACK, MSG_ARM, s.vseq, NK_WRONG_STATE);
            end
            l = push(l, KIND_NACK, MSG_FIRE, item_i.cmd_seq, NK_WRONG_STATE);
          end else if (item_i.cmd == CMD_BATT_CRIT) begin
            if (s.vp) begin
              s = verify_clear(relays_safe(s));
              l = push(l, KIND_NACK, MSG_ARM, s.vseq, NK_LOW_BATT);
            end
            s = go_error(s, ERRB_VBAT);
          end else if (item_i.cmd == CMD_LINK_LOST) begin
            if (s.vp) s = verify_clear(relays_safe(s));
            s = go_link_lost(s);
          end
        end
        ST_ARMED: begin
          if (item_i.cmd == CMD_LAUNCH) begin
            if (ch != {4'd0, s.ach}) begin
              l = push(l, KIND_NACK, MSG_FIRE, item_i.cmd_seq, NK_WRONG_STATE);
            end else if (!item_i.arm_sense_on) begin
              l = push(l, KIND_NACK, MSG_FIRE, item_i.cmd_seq, NK_SWITCH_OFF);
              s = go_disarm(s);
            end else begin
              s.pst = t;
              s.ast = 32'd0;
              s.lft = item_i.rx_time_ms;
              s.sir = SIREN_CONT;
              s.led = LED_PREFIRE;
              l = push(l, KIND_ACK, MSG_FIRE, item_i.cmd_seq, {4'd0, s.ach});
              s.st = ST_PREFIRE;
            end
          end else if (item_i.cmd == CMD_DISARM) begin
            l = push(l, KIND_ACK, MSG_DISARM, item_i.cmd_seq, ch);
            s = go_disarm(s);
          end else if (item_i.cmd == CMD_CEASE) begin
            l = push(l, KIND_ACK, MSG_CEASE, item_i.cmd_seq, 8'd0);
            s = go_disarm(s);
          end else if (item_i.cmd == CMD_ARM) begin
            l = push(l, KIND_NACK, MSG_ARM, item_i.cmd_seq, NK_ALREADY_ARMED);
          end else if (nlvl) s = go_disarm(s);
          else if (item_i.cmd == CMD_BATT_CRIT) s = go_error(s, ERRB_VBAT);
          else if (item_i.cmd == CMD_LINK_LOST) s = go_link_lost(s);
        end
        ST_PREFIRE: begin
          if (item_i.cmd == CMD_CEASE) begin
            l = push(l, KIND_ACK, MSG_CEASE, item_i.cmd_seq, 8'd0);
            s = go_disarm(s);
          end else if (item_i.cmd == CMD_LAUNCH) begin
            if (ch == {4'd0, s.ach}) s.lft = item_i.rx_time_ms;
          end else if (nlvl) s = go_disarm(s);
          else if (item_i.cmd == CMD_DISARM) begin
            l = push(l, KIND_ACK, MSG_DISARM, item_i.cmd_seq, ch);
            s = go_disarm(s);
          end else if (item_i.cmd == CMD_ARM) begin
            l = push(l, KIND_NACK, MSG_ARM, item_i.cmd_seq, NK_WRONG_STATE);
          end else if (item_i.cmd == CMD_BATT_CRIT) s = go_error(s, ERRB_VBAT);
          else if (item_i.cmd == CMD_LINK_LOST) s = go_link_lost(s);
        end
        ST_FIRING: begin
          if (item_i.cmd == CMD_PULSE_END) begin
            s = relays_safe(s);
            s.sir = SIREN_QUIET;
            s.fch = 4'd0;
            s.ach = 4'd0;
            s.led = LED_STATUS;
            if (s.llp) begin
              s.llp = 1'b0;
              s.sir = SIREN_LINK;
              s.st = ST_LINKLOST;
            end else begin
              s.post = t;
              s.st = ST_POSTFIRE;
            end
          end else if (item_i.cmd == CMD_CEASE) begin
            s = firing_to_idle(s);
            l = push(l, KIND_ACK, MSG_CEASE, item_i.cmd_seq, 8'd0);
          end else if (nlvl) s = firing_to_idle(s);
          else if (item_i.cmd == CMD_ARM) begin
            l = push(l, KIND_NACK, MSG_ARM, item_i.cmd_seq, NK_WRONG_STATE);
          end else if (item_i.cmd == CMD_DISARM) begin
            s = firing_to_idle(s);
            l = push(l, KIND_ACK, MSG_DISARM, item_i.cmd_seq, 8'd0);
          end else if (item_i.cmd == CMD_BATT_CRIT) s.ef = s.ef | ERRB_VBAT;
          else if (item_i.cmd == CMD_LINK_LOST) begin
            if (cfg_i.pulse_ll) s.llp = 1'b1;
            else begin
              s = relays_safe(s);
              s.fch = 4'd0;
              s.ach = 4'd0;
              s.sir = SIREN_LINK;
              s.led = LED_STATUS;
              s.st = ST_LINKLOST;
            end
          end
        end
        ST_POSTFIRE: begin
          if (item_i.cmd == CMD_ARM) begin
            l = push(l, KIND_NACK, MSG_ARM, item_i.cmd_seq, NK_WRONG_STATE);
          end else if (item_i.cmd == CMD_CEASE) begin
            l = push(l, KIND_ACK, MSG_CEASE, item_i.cmd_seq, 8'd0);
          end else if (item_i.cmd == CMD_DISARM) begin
            l = push(l, KIND_ACK, MSG_DISARM, item_i.cmd_seq, ch);
          end else if (item_i.cmd == CMD_LINK_LOST) s = go_link_lost(s);
          else if (item_i.cmd == CMD_BATT_CRIT) s = go_error(s, ERRB_VBAT);
          if (s.ef[1]) s = go_error(s, ERRB_NONE);
        end
        ST_LINKLOST: begin
          if (item_i.cmd == CMD_LINK_REC) begin
            s.sir = SIREN_QUIET;
            s.led = LED_STATUS;
            s.st = ST_IDLE;
          end
        end
        ST_ERROR: begin
        end
        default: begin
        end
      endcase
    end

    // timer rules
    if (s.vp && s.vst != 32'd0 && (t - s.vst) >= {16'd0, cfg_i.verify_to}) begin
      s = verify_clear(relays_safe(s));
      l = push(l, KIND_NACK, MSG_ARM, s.vseq, NK_SENSE_FAULT);
    end
    if (s.st == ST_ARMED && s.ast != 32'd0 && (t - s.ast) >= cfg_i.arm_to) s = go_disarm(s);
    if (s.st == ST_PREFIRE && s.pst != 32'd0 && (t - s.pst) >= cfg_i.prefire) begin
      dm = s.lft != 32'd0 && (t - s.lft) < cfg_i.auth_to;
      if (!dm || !item_i.link_healthy || !item_i.key_on || !item_i.arm_sense_on) begin
        s = go_disarm(s);
      end else begin
        s.fch = s.ach;
        s.frr = s.ach;
        s.led = LED_FIRING;
        s.st = ST_FIRING;
      end
    end
    if (s.st == ST_POSTFIRE && s.post != 32'd0) begin
      if (s.ef[1]) begin
        s.post = 32'd0;
        s = go_error(s, ERRB_NONE);
      end else if ((t - s.post) >= cfg_i.cooldown) begin
        s.post = 32'd0;
        s.led = LED_STATUS;
        s.st = ST_IDLE;
      end
    end

    if (l.n == 2'd0) l = push(l, KIND_NONE, MSG_ARM, 32'd0, 8'd0);

    nxt_o = s;
    bundle_o.r = l;
    bundle_o.s = '{st: s.st, ach: s.ach, ef: s.ef, arr: s.arr, frr: s.frr,
                   sir: s.sir, led: s.led};
  end

endmodule

[design/fsi_outq.sv]
module fsi_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  fsi_pkg::bundle_t bundle_i,
  output logic             full_o,
  fsi_out_if.source        out_ch
);
  import fsi_pkg::*;

  bundle_t    mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r, idx_nxt;
  bundle_t    head;
  reply_t     rp;
  logic       is_last;
  logic       pop;

  assign head = mem_r[rd_ptr_r];
  assign rp = head.r.rep[idx_r];
  assign is_last = (idx_r == head.r.n - 2'd1);
  assign pop = out_ch.valid && out_ch.ready && is_last;
  assign full_o = (cnt_r == 2'd2);

  assign out_ch.valid = (cnt_r != 2'd0);
  assign out_ch.item = '{reply_kind: rp.kind, reply_msg: rp.msg, reply_seq: rp.seq,
                         reply_value: rp.val, fsm_state: head.s.st,
                         armed_chan: head.s.ach, error_bits: head.s.ef,
                         arm_relay: head.s.arr, fire_relay_chan: head.s.frr,
                         siren_mode: head.s.sir, led_mode: head.s.led, last: is_last};

  always_comb begin
    wr_ptr_nxt = push_i ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt = cnt_r + (push_i ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
    idx_nxt = idx_r;
    if (out_ch.valid && out_ch.ready) idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_ptr_r] <= bundle_i;
  end

endmodule

[design/firing_sequence_interlock_core.sv]
// an accepted item's results are registered in the result buffer, then offered
// throughput: one item per cycle while each item gives one result and results are taken;
// results leave one per cycle, so an item with two or three results holds the result port
// until its last leaves, and the two-entry result buffer takes one more item meanwhile before input waits
// reset: synchronous active low rst_n, state to boot, registers to defaults
module firing_sequence_interlock_core #(
  parameter int NUM_CHAN = fsi_pkg::NUM_CHAN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fsi_in_if.sink      in_ch,
  fsi_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data
);
  import fsi_pkg::*;

  // interlock state, updated once per accepted item
  core_t   core_r, core_nxt;
  cfg_t    cfg_r;
  bundle_t bundle;
  logic    full;
  logic    accept;

  // take a new item whenever the result buffer has a free slot
  assign in_ch.ready = !full;
  assign accept = in_ch.valid && in_ch.ready;

  // event rule then timer rules, all in one pass
  fsi_step #(.NUM_CHAN(NUM_CHAN)) u_step (
    .cur_i    (core_r),
    .cfg_i    (cfg_r),
    .item_i   (in_ch.item),
    .nxt_o    (core_nxt),
    .bundle_o (bundle)
  );

  // results of one item wait here and leave one per cycle while the result side is ready
  fsi_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (accept),
    .bundle_i (bundle),
    .full_o   (full),
    .out_ch   (out_ch)
  );

  // all-zero state is boot with relays open, siren off and led on status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_r <= '0;
    end else if (accept) begin
      core_r <= core_nxt;
    end
  end

  // configuration registers, values masked to their widths
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.arm_to <= 32'd60000;
      cfg_r.prefire <= 32'd3000;
      cfg_r.auth_to <= 32'd500;
      cfg_r.cooldown <= 32'd5000;
      cfg_r.verify_to <= 16'd200;
      cfg_r.min_batt <= 16'd11000;
      cfg_r.prot_mask <= 8'hFF;
      cfg_r.pulse_ll <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ARM_TO:    cfg_r.arm_to <= cfg_data;
        REG_PREFIRE:   cfg_r.prefire <= cfg_data;
        REG_AUTH_TO:   cfg_r.auth_to <= cfg_data;
        REG_COOLDOWN:  cfg_r.cooldown <= cfg_data;
        REG_VERIFY_TO: cfg_r.verify_to <= cfg_data[15:0];
        REG_MIN_BATT:  cfg_r.min_batt <= cfg_data[15:0];
        REG_PROT_MASK: cfg_r.prot_mask <= cfg_data[7:0];
        REG_PULSE_LL:  cfg_r.pulse_ll <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

[bench/firing_sequence_interlock_core_tb.sv]
module firing_sequence_interlock_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fsi_pkg::*;

  // predicts the interlock's results and holds them until the block emits them
  class interlock_scoreboard;
    out_item_t pending_q[$];
    int errors, checked, accepted;

    // register copies
    logic [31:0] arm_to, pre_dly, auth_to, cool;
    logic [15:0] ver_to, min_mv;
    logic [7:0] mask;
    logic pulse_ll;

    // sequencer state
    st_t st;
    logic [3:0] ach, fch, vch, frr;
    logic [1:0] ef;
    logic [31:0] ast, pst, post, vst, vseq, lft;
    logic vp, llp, arr;
    logic [2:0] sir, led;

    // replies of the current item
    logic [1:0] rk[3], rm[3];
    logic [31:0] rs[3];
    logic [7:0] rv[3];
    int nr;

    function new();
      arm_to = 60000; pre_dly = 3000; auth_to = 500; cool = 5000;
      ver_to = 200; min_mv = 11000; mask = 8'hff; pulse_ll = 1'b1;
      st = ST_BOOT; ach = 0; fch = 0; vch = 0; frr = 0; ef = ERRB_NONE;
      ast = 0; pst = 0; post = 0; vst = 0; vseq = 0; lft = 0;
      vp = 0; llp = 0; arr = 0; sir = SIREN_QUIET; led = LED_STATUS;
      errors = 0; checked = 0; accepted = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_ARM_TO:    arm_to = d;
        REG_PREFIRE:   pre_dly = d;
        REG_AUTH_TO:   auth_to = d;
        REG_COOLDOWN:  cool = d;
        REG_VERIFY_TO: ver_to = d[15:0];
        REG_MIN_BATT:  min_mv = d[15:0];
        REG_PROT_MASK: mask = d[7:0];
        REG_PULSE_LL:  pulse_ll = d[0];
        default: ;
      endcase
    endfunction

    function void add_reply(logic [1:0] k, logic [1:0] m, logic [31:0] s, logic [7:0] v);
      if (nr < MAX_REP) begin
        rk[nr] = k; rm[nr] = m; rs[nr] = s; rv[nr] = v;
        nr++;
      end
    endfunction

    function void relays_off();
      arr = 0; frr = 0;
    endfunction

    function void clear_run();
      relays_off();
      ach = 0; fch = 0; ast = 0; pst = 0; lft = 0; llp = 0;
      led = LED_STATUS;
    endfunction

    function void to_idle();
      clear_run(); sir = SIREN_QUIET; st = ST_IDLE;
    endfunction

    function void to_linklost();
      clear_run(); sir = SIREN_LINK; st = ST_LINKLOST;
    endfunction

    function void to_error(logic [1:0] flag);
      clear_run();
      sir = SIREN_ERR; led = LED_ERROR; ef = ef | flag; post = 0; st = ST_ERROR;
    endfunction

    function void drop_verify();
      vp = 0; vch = 0; vst = 0;
    endfunction

    function void abort_verify(logic [7:0] why);
      relays_off(); drop_verify();
      add_reply(KIND_NACK, MSG_ARM, vseq, why);
    endfunction

    function void enter_armed(logic [3:0] ch, logic [31:0] t, logic [31:0] sq);
      ach = ch; ast = t; sir = SIREN_PULSE; led = LED_ARMED;
      add_reply(KIND_ACK, MSG_ARM, sq, {4'd0, ch});
      st = ST_ARMED;
    endfunction

    function void firing_idle();
      relays_off(); sir = SIREN_QUIET; fch = 0; ach = 0; llp = 0;
      led = LED_STATUS; st = ST_IDLE;
    endfunction

    // nack reason for an arm request, -1 when every guard passes
    function int arm_refusal(in_item_t it);
      if (it.channel < 1 || it.channel > NUM_CHAN_DEF) return NK_INVALID_CH;
      if (ach != 0) return NK_ALREADY_ARMED;
      if (!mask[(it.channel - 1) & 7]) return NK_INVALID_CH;
      if (!it.key_on) return NK_SWITCH_OFF;
      if (it.continuity_open) return NK_NO_CONT;
      if (it.battery_mv < min_mv) return NK_LOW_BATT;
      if (!it.link_healthy) return NK_COMM;
      return -1;
    endfunction

    function void event_rule(in_item_t it);
      logic [31:0] t;
      logic drop;
      int why;
      logic [3:0] vc;
      t = it.time_ms;
      drop = (it.cmd == CMD_SENSE || it.cmd == CMD_KEY) && !it.level;
      if (it.cmd == CMD_WELD) begin
        if (st != ST_ERROR) begin
          if (vp) begin
            drop_verify();
            add_reply(KIND_NACK, MSG_ARM, vseq, NK_SENSE_FAULT);
          end
          to_error(ERRB_RELAY);
        end
        return;
      end
      case (st)
        ST_BOOT: if (it.cmd == CMD_LINK_UP) begin
          st = ST_IDLE; led = LED_STATUS;
        end
        ST_IDLE: begin
          if (it.cmd == CMD_ARM) begin
            why = arm_refusal(it);
            if (why >= 0) begin
              add_reply(KIND_NACK, MSG_ARM, it.cmd_seq, 8'(why));
              return;
            end
            arr = 1;
            if (it.arm_sense_on) enter_armed(it.channel[3:0], t, it.cmd_seq);
            else begin
              vp = 1; vch = it.channel[3:0]; vseq = it.cmd_seq; vst = t;
            end
          end else if (it.cmd == CMD_SENSE) begin
            if (vp && it.level) begin
              vc = vch;
              drop_verify();
              enter_armed(vc, t, vseq);
            end
          end else if (it.cmd == CMD_DISARM) begin
            add_reply(KIND_ACK, MSG_DISARM, it.cmd_seq, it.channel);
          end else if (it.cmd == CMD_CEASE) begin
            if (vp) abort_verify(NK_WRONG_STATE);
            add_reply(KIND_ACK, MSG_CEASE, it.cmd_seq, 0);
          end else if (it.cmd == CMD_LAUNCH) begin
            if (vp) abort_verify(NK_WRONG_STATE);
            add_reply(KIND_NACK, MSG_FIRE, it.cmd_seq, NK_WRONG_STATE);
          end else if (it.cmd == CMD_BATT_CRIT) begin
            if (vp) abort_verify(NK_LOW_BATT);
            to_error(ERRB_VBAT);
          end else if (it.cmd == CMD_LINK_LOST) begin
            if (vp) begin
              relays_off(); drop_verify();
            end
            to_linklost();
          end
        end
        ST_ARMED: begin
          if (it.cmd == CMD_LAUNCH) begin
            if (it.channel != {4'd0, ach}) begin
              add_reply(KIND_NACK, MSG_FIRE, it.cmd_seq, NK_WRONG_STATE);
              return;
            end
            if (!it.arm_sense_on) begin
              add_reply(KIND_NACK, MSG_FIRE, it.cmd_seq, NK_SWITCH_OFF);
              to_idle();
              return;
            end
            pst = t; ast = 0; lft = it.rx_time_ms;
            sir = SIREN_CONT; led = LED_PREFIRE;
            add_reply(KIND_ACK, MSG_FIRE, it.cmd_seq, {4'd0, ach});
            st = ST_PREFIRE;
          end else if (it.cmd == CMD_DISARM) begin
            add_reply(KIND_ACK, MSG_DISARM, it.cmd_seq, it.channel); to_idle();
          end else if (it.cmd == CMD_CEASE) begin
            add_reply(KIND_ACK, MSG_CEASE, it.cmd_seq, 0); to_idle();
          end else if (it.cmd == CMD_ARM)
            add_reply(KIND_NACK, MSG_ARM, it.cmd_seq, NK_ALREADY_ARMED);
          else if (drop) to_idle();
          else if (it.cmd == CMD_BATT_CRIT) to_error(ERRB_VBAT);
          else if (it.cmd == CMD_LINK_LOST) to_linklost();
        end
        ST_PREFIRE: begin
          if (it.cmd == CMD_CEASE) begin
            add_reply(KIND_ACK, MSG_CEASE, it.cmd_seq, 0); to_idle();
          end else if (it.cmd == CMD_LAUNCH) begin
            if (it.channel == {4'd0, ach}) lft = it.rx_time_ms;
          end else if (drop) to_idle();
          else if (it.cmd == CMD_DISARM) begin
            add_reply(KIND_ACK, MSG_DISARM, it.cmd_seq, it.channel); to_idle();
          end else if (it.cmd == CMD_ARM)
            add_reply(KIND_NACK, MSG_ARM, it.cmd_seq, NK_WRONG_STATE);
          else if (it.cmd == CMD_BATT_CRIT) to_error(ERRB_VBAT);
          else if (it.cmd == CMD_LINK_LOST) to_linklost();
        end
        ST_FIRING: begin
          if (it.cmd == CMD_PULSE_END) begin
            relays_off(); sir = SIREN_QUIET; fch = 0; ach = 0; led = LED_STATUS;
            if (llp) begin
              llp = 0; sir = SIREN_LINK; st = ST_LINKLOST;
            end else begin
              post = t; st = ST_POSTFIRE;
            end
          end else if (it.cmd == CMD_CEASE) begin
            firing_idle(); add_reply(KIND_ACK, MSG_CEASE, it.cmd_seq, 0);
          end else if (drop) firing_idle();
          else if (it.cmd == CMD_ARM)
            add_reply(KIND_NACK, MSG_ARM, it.cmd_seq, NK_WRONG_STATE);
          else if (it.cmd == CMD_DISARM) begin
            firing_idle(); add_reply(KIND_ACK, MSG_DISARM, it.cmd_seq, 0);
          end else if (it.cmd == CMD_BATT_CRIT) ef = ef | ERRB_VBAT;
          else if (it.cmd == CMD_LINK_LOST) begin
            if (pulse_ll) llp = 1;
            else begin
              relays_off(); fch = 0; ach = 0;
              sir = SIREN_LINK; led = LED_STATUS; st = ST_LINKLOST;
            end
          end
        end
        ST_POSTFIRE: begin
          if (it.cmd == CMD_ARM) add_reply(KIND_NACK, MSG_ARM, it.cmd_seq, NK_WRONG_STATE);
          else if (it.cmd == CMD_CEASE) add_reply(KIND_ACK, MSG_CEASE, it.cmd_seq, 0);
          else if (it.cmd == CMD_DISARM)
            add_reply(KIND_ACK, MSG_DISARM, it.cmd_seq, it.channel);
          else if (it.cmd == CMD_LINK_LOST) to_linklost();
          else if (it.cmd == CMD_BATT_CRIT) to_error(ERRB_VBAT);
          if (ef & ERRB_VBAT) to_error(ERRB_NONE);
        end
        ST_LINKLOST: if (it.cmd == CMD_LINK_REC) begin
          sir = SIREN_QUIET; led = LED_STATUS; st = ST_IDLE;
        end
        default: ;
      endcase
    endfunction

    function void timer_rule(in_item_t it);
      logic [31:0] t;
      logic auth_ok;
      t = it.time_ms;
      if (vp && vst != 0 && (t - vst) >= {16'd0, ver_to}) abort_verify(NK_SENSE_FAULT);
      if (st == ST_ARMED && ast != 0 && (t - ast) >= arm_to) to_idle();
      if (st == ST_PREFIRE && pst != 0 && (t - pst) >= pre_dly) begin
        auth_ok = lft != 0 && (t - lft) < auth_to;
        if (!auth_ok || !it.link_healthy || !it.key_on || !it.arm_sense_on) begin
          to_idle();
          return;
        end
        fch = ach; frr = ach; led = LED_FIRING; st = ST_FIRING;
      end
      if (st == ST_POSTFIRE && post != 0) begin
        if (ef & ERRB_VBAT) begin
          post = 0; to_error(ERRB_NONE);
          return;
        end
        if ((t - post) >= cool) begin
          post = 0; led = LED_STATUS; st = ST_IDLE;
        end
      end
    endfunction

    function void note_input(in_item_t it);
      out_item_t o;
      nr = 0;
      accepted++;
      event_rule(it);
      timer_rule(it);
      if (nr == 0) add_reply(KIND_NONE, MSG_ARM, 0, 0);
      for (int k = 0; k < nr; k++) begin
        o.reply_kind = rk[k]; o.reply_msg = rm[k]; o.reply_seq = rs[k]; o.reply_value = rv[k];
        o.fsm_state = st; o.armed_chan = ach; o.error_bits = ef; o.arm_relay = arr;
        o.fire_relay_chan = frr; o.siren_mode = sir; o.led_mode = led;
        o.last = (k == nr - 1);
        pending_q.push_back(o);
      end
    endfunction

    function bit field_ok(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        return 0;
      end
      return 1;
    endfunction

    function void check_result(out_item_t a);
      out_item_t e;
      bit ok;
      checked++;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: %p", a);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      ok = 1;
      ok &= field_ok("reply_kind", e.reply_kind, a.reply_kind);
      ok &= field_ok("reply_msg", e.reply_msg, a.reply_msg);
      ok &= field_ok("reply_seq", e.reply_seq, a.reply_seq);
      ok &= field_ok("reply_value", e.reply_value, a.reply_value);
      ok &= field_ok("fsm_state", e.fsm_state, a.fsm_state);
      ok &= field_ok("armed_chan", e.armed_chan, a.armed_chan);
      ok &= field_ok("error_bits", e.error_bits, a.error_bits);
      ok &= field_ok("arm_relay", e.arm_relay, a.arm_relay);
      ok &= field_ok("fire_relay_chan", e.fire_relay_chan, a.fire_relay_chan);
      ok &= field_ok("siren_mode", e.siren_mode, a.siren_mode);
      ok &= field_ok("led_mode", e.led_mode, a.led_mode);
      ok &= field_ok("last", e.last, a.last);
      if (!ok) errors++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [31:0] cfg_data;

  fsi_in_if in_if();
  fsi_out_if out_if();

  firing_sequence_interlock_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  interlock_scoreboard sb;
  logic [31:0] now_ms;
  bit quiet;         // no idling on either side
  bit allow_trap;    // weld and battery-critical lock the block in error until reset
  int cfg_phases;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // result side: random stall bursts plus one long hold-off so the block backs up
  initial begin : result_sink
    int stall;
    bit held;
    stall = 0;
    held = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.item);
      if (!held && sb != null && sb.checked >= 60) begin
        held = 1;
        stall = 90;
      end
      if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (!quiet && rst_n && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 16) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= rst_n;
      end
    end
  end

  // offer one item and wait for it to be taken; valid stays high afterwards
  task automatic send(in_item_t it);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.item <= it;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    sb.note_input(it);
  endtask

  // a command with healthy sensors
  function automatic in_item_t mk(logic [3:0] cmd, logic [31:0] t, logic [7:0] ch,
                                  logic sense);
    in_item_t it;
    it.cmd = cmd; it.time_ms = t; it.channel = ch; it.cmd_seq = $urandom;
    it.rx_time_ms = t; it.level = 1'b1; it.key_on = 1'b1; it.arm_sense_on = sense;
    it.continuity_open = 1'b0; it.battery_mv = 16'd12000; it.link_healthy = 1'b1;
    return it;
  endfunction

  // drain, then rewrite every register while the block sits idle
  task automatic write_regs(logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
                            logic [31:0] v3, logic [31:0] v4, logic [31:0] v5,
                            logic [31:0] v6, logic [31:0] v7);
    logic [2:0] idx[8];
    logic [31:0] val[8];
    idx = '{REG_ARM_TO, REG_PREFIRE, REG_AUTH_TO, REG_COOLDOWN,
            REG_VERIFY_TO, REG_MIN_BATT, REG_PROT_MASK, REG_PULSE_LL};
    val = '{v0, v1, v2, v3, v4, v5, v6, v7};
    in_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_idx <= idx[i];
      cfg_data <= val[i];
      sb.set_reg(idx[i], val[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_phases++;
  endtask

  // mostly well-formed launch sequences steered by the predicted state, some noise
  task automatic random_run(int count, int span);
    in_item_t it;
    logic [3:0] c;
    for (int n = 0; n < count; n++) begin
      now_ms += $urandom_range(0, span);
      it = mk(CMD_TICK, now_ms, 8'($urandom_range(1, NUM_CHAN_DEF)), 1'b1);
      if ($urandom_range(0, 9) == 0) it.channel = 8'($urandom_range(0, 255));
      else if (sb.ach != 0 && $urandom_range(0, 3) != 0) it.channel = {4'd0, sb.ach};
      it.rx_time_ms = ($urandom_range(0, 9) == 0) ? $urandom : now_ms - $urandom_range(0, 5);
      it.level = $urandom_range(0, 4) != 0;
      it.key_on = $urandom_range(0, 7) != 0;
      it.arm_sense_on = $urandom_range(0, 5) != 0;
      it.continuity_open = $urandom_range(0, 9) == 0;
      it.battery_mv = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(11000, 65535));
      it.link_healthy = $urandom_range(0, 9) != 0;
      if ($urandom_range(0, 3) != 0) begin
        case (sb.st)
          ST_BOOT:     c = CMD_LINK_UP;
          ST_IDLE:     c = (sb.vp && $urandom_range(0, 1)) ? CMD_SENSE : CMD_ARM;
          ST_ARMED:    c = CMD_LAUNCH;
          ST_PREFIRE:  c = $urandom_range(0, 1) ? CMD_LAUNCH : CMD_TICK;
          ST_FIRING:   c = ($urandom_range(0, 2) == 0) ? CMD_PULSE_END : CMD_TICK;
          ST_LINKLOST: c = CMD_LINK_REC;
          default:     c = CMD_TICK;
        endcase
      end else begin
        c = 4'($urandom_range(0, 15));
        if (!allow_trap && (c == CMD_WELD || c == CMD_BATT_CRIT)) c = CMD_TICK;
      end
      it.cmd = c;
      send(it);
    end
  endtask

  initial begin : stimulus
    in_item_t it;
    int tries;
    sb = new();
    quiet = 0;
    allow_trap = 0;
    cfg_phases = 0;
    in_if.valid <= 1'b0;
    in_if.item <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_ARM_TO;
    cfg_data <= '0;
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: boot, every arm refusal, verify paths, a full firing with link loss
    send(mk(CMD_TICK, 100, 1, 1));
    send(mk(CMD_ARM, 200, 1, 1));              // ignored in boot
    send(mk(CMD_LINK_UP, 300, 0, 1));
    send(mk(CMD_ARM, 310, 0, 1));              // channel zero
    send(mk(CMD_ARM, 320, 255, 1));            // channel out of range
    it = mk(CMD_ARM, 330, 1, 1); it.key_on = 0; send(it);
    it = mk(CMD_ARM, 340, 1, 1); it.continuity_open = 1; send(it);
    it = mk(CMD_ARM, 350, 1, 1); it.battery_mv = 10999; send(it);
    it = mk(CMD_ARM, 360, 1, 1); it.link_healthy = 0; send(it);
    send(mk(CMD_ARM, 0, 8, 0));                // verify started at time zero never expires
    send(mk(CMD_TICK, 1000, 0, 0));
    send(mk(CMD_SENSE, 1100, 0, 1));           // relay sense completes arming
    send(mk(CMD_ARM, 1150, 2, 1));             // already armed
    send(mk(CMD_LAUNCH, 1180, 3, 1));          // wrong channel
    send(mk(CMD_LAUNCH, 1200, 8, 1));
    send(mk(CMD_LAUNCH, 4000, 8, 1));          // dead-man refresh
    send(mk(CMD_TICK, 4200, 0, 1));            // countdown over, relay closes
    send(mk(CMD_LINK_LOST, 4210, 0, 1));       // pulse finishes first
    send(mk(CMD_PULSE_END, 4300, 0, 1));
    send(mk(CMD_LINK_REC, 4400, 0, 1));
    send(mk(CMD_ARM, 5000, 3, 0));
    send(mk(CMD_TICK, 5300, 0, 0));            // verify times out
    send(mk(CMD_ARM, 6000, 2, 0));
    send(mk(CMD_CEASE, 6010, 0, 0));           // aborts the verify, then acks
    send(mk(CMD_ARM, 6100, 1, 1));
    send(mk(CMD_DISARM, 6200, 1, 1));
    send(mk(CMD_ARM, 7000, 4, 0));
    send(mk(CMD_LAUNCH, 7010, 4, 0));          // aborts the verify, fire refused
    send(mk(CMD_TICK + 4'd15, 7100, 0, 1));    // unknown command code

    // short timers so sequences run to completion
    write_regs(300, 20, 40, 15, 25, 11000, $urandom_range(0, 255) | 8'h81, 1);
    now_ms = 32'd8000;
    random_run(100, 12);

    // extremes, with the clock wrapping through zero
    write_regs(1, 1, 32'hffff_ffff, 0, 16'hffff, 0, 8'hff, 1);
    now_ms = 32'hffff_ffc0;
    random_run(80, 6);

    // everything hard to arm
    write_regs(32'hffff_ffff, 5, 1, 32'hffff_ffff, 1, 16'hffff, 0, 0);
    random_run(40, 4);

    // last part without idling, link loss drops the pulse at once
    write_regs(250, 15, 60, 10, 30, 0, 8'hff, 0);
    quiet = 1;
    random_run(60, 10);

    // run into firing, then the faults that lock the block in error
    tries = 0;
    while (sb.st != ST_FIRING && tries < 20) begin
      random_run(1, 3);
      tries++;
    end
    now_ms += 1;
    send(mk(CMD_BATT_CRIT, now_ms, 0, 1));
    send(mk(CMD_WELD, now_ms + 1, 0, 1));
    send(mk(CMD_WELD, now_ms + 2, 0, 1));      // no effect once in error
    send(mk(CMD_LINK_UP, now_ms + 3, 0, 1));

    in_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("run: %0d items in, %0d results checked over %0d register settings",
             sb.accepted, sb.checked, cfg_phases + 1);
    $display("final state %0d, error bits %0d", sb.st, sb.ef);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
